// ===== rtl/core/hse_pkg.sv =====
`timescale 1ns / 1ps

package hse_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W    = $clog2(MAX_ITEMS);

    typedef logic [3:0] op_t;

    // Datapath operations issued by the controller, one per cycle.
    localparam op_t OP_NONE       = 4'd0;
    localparam op_t OP_LOAD       = 4'd1;
    localparam op_t OP_BUILD_INIT = 4'd2;
    localparam op_t OP_BUILD_NEXT = 4'd3;
    localparam op_t OP_RD_NODE    = 4'd4;
    localparam op_t OP_LATCH_CUR  = 4'd5;
    localparam op_t OP_RD_LEFT    = 4'd6;
    localparam op_t OP_CMP_LEFT   = 4'd7;
    localparam op_t OP_CMP_RIGHT  = 4'd8;
    localparam op_t OP_WR_NODE    = 4'd9;
    localparam op_t OP_WR_BEST    = 4'd10;
    localparam op_t OP_RD_ROOT    = 4'd11;
    localparam op_t OP_RD_LAST    = 4'd12;
    localparam op_t OP_EMIT       = 4'd13;

    typedef struct packed {
        logic last_beat;  // the final beat of a set was accepted
        logic half_zero;  // the stored set has no internal node
        logic left_out;   // left child of the current node lies outside the heap
        logic swap;       // the best of node and children is a child
        logic bidx_one;   // the build pass just finished the root
        logic size_one;   // the heap holds a single entry
        logic out_free;   // the output register can take a result this cycle
    } sts_t;

    // True when a must sit above b in the heap.
    function automatic logic ranks_above(logic signed [DATA_W-1:0] a,
                                         logic signed [DATA_W-1:0] b,
                                         logic descending);
        ranks_above = descending ? (a > b) : (a < b);
    endfunction

    // One-based heap index to zero-based memory address.
    function automatic logic [ADDR_W-1:0] idx_to_addr(logic [CNT_W-1:0] idx);
        logic [CNT_W-1:0] tmp;
        tmp = idx - CNT_W'(1);
        idx_to_addr = tmp[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/hse_ram.sv =====
`timescale 1ns / 1ps

module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/hse_datapath.sv =====
`timescale 1ns / 1ps

module hse_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hse_pkg::op_t                  op,
    output hse_pkg::sts_t                 sts,
    input  logic                          cfg_wen,
    input  logic                          cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hse_pkg::DATA_W-1:0]    s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hse_pkg::DATA_W-1:0]    m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);

    import hse_pkg::*;

    logic                sort_order_reg;
    logic [CNT_W-1:0]    count_reg, size_reg, node_reg, bidx_reg, best_idx_reg;
    logic                ovf_reg;
    logic [DATA_W-1:0]   cur_reg, best_val_reg, top_reg;
    logic [DATA_W-1:0]   out_val_reg;
    logic                out_last_reg, out_ovf_reg, out_valid_reg;

    logic [CNT_W:0]      left_idx, right_idx, size_ext;
    logic                accept, has_room, out_free, right_in;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [DATA_W-1:0]   ram_wdata, ram_rdata;

    assign left_idx  = {node_reg, 1'b0};
    assign right_idx = {node_reg, 1'b1};
    assign size_ext  = {1'b0, size_reg};
    assign right_in  = right_idx <= size_ext;
    assign has_room  = count_reg < CNT_W'(MAX_ITEMS);
    assign s_tready  = (op == OP_LOAD);
    assign accept    = s_tready && s_tvalid;
    assign out_free  = !out_valid_reg || m_tready;

    assign sts.last_beat = accept && s_tlast;
    assign sts.half_zero = (count_reg >> 1) == '0;
    assign sts.left_out  = left_idx > size_ext;
    assign sts.swap      = best_idx_reg != node_reg;
    assign sts.bidx_one  = bidx_reg == CNT_W'(1);
    assign sts.size_one  = size_reg == CNT_W'(1);
    assign sts.out_free  = out_free;

    // Memory port steering for each operation.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (op)
            OP_LOAD:
            begin
                ram_we    = accept && has_room;
                ram_waddr = count_reg[ADDR_W-1:0];
                ram_wdata = s_tdata;
            end
            OP_RD_NODE:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_to_addr(node_reg);
            end
            OP_RD_LEFT:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_to_addr(left_idx[CNT_W-1:0]);
            end
            OP_CMP_LEFT:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_to_addr(right_idx[CNT_W-1:0]);
            end
            OP_WR_NODE:
            begin
                ram_we    = sts.swap;
                ram_waddr = idx_to_addr(node_reg);
                ram_wdata = best_val_reg;
            end
            OP_WR_BEST:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_to_addr(best_idx_reg);
                ram_wdata = cur_reg;
            end
            OP_RD_ROOT:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            OP_RD_LAST:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_to_addr(size_reg);
            end
            OP_EMIT:
            begin
                // The last heap entry moves to the root.
                ram_we    = out_free;
                ram_waddr = '0;
                ram_wdata = ram_rdata;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    hse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_order_reg <= 1'b0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                sort_order_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (has_room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (op == OP_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (sts.size_one)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_BUILD_INIT:
            begin
                size_reg <= count_reg;
                bidx_reg <= count_reg >> 1;
                node_reg <= count_reg >> 1;
            end
            OP_BUILD_NEXT:
            begin
                bidx_reg <= bidx_reg - CNT_W'(1);
                node_reg <= bidx_reg - CNT_W'(1);
            end
            OP_LATCH_CUR:
            begin
                cur_reg <= ram_rdata;
            end
            OP_CMP_LEFT:
            begin
                if (ranks_above(ram_rdata, cur_reg, sort_order_reg))
                begin
                    best_idx_reg <= left_idx[CNT_W-1:0];
                    best_val_reg <= ram_rdata;
                end
                else
                begin
                    best_idx_reg <= node_reg;
                    best_val_reg <= cur_reg;
                end
            end
            OP_CMP_RIGHT:
            begin
                if (right_in && ranks_above(ram_rdata, best_val_reg, sort_order_reg))
                begin
                    best_idx_reg <= right_idx[CNT_W-1:0];
                    best_val_reg <= ram_rdata;
                end
            end
            OP_WR_BEST:
            begin
                node_reg <= best_idx_reg;
            end
            OP_RD_LAST:
            begin
                top_reg <= ram_rdata;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    cur_reg      <= ram_rdata;
                    node_reg     <= CNT_W'(1);
                    size_reg     <= size_reg - CNT_W'(1);
                    out_val_reg  <= top_reg;
                    out_last_reg <= sts.size_one;
                    out_ovf_reg  <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("stored item count beyond capacity");

    a_left_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_CMP_LEFT) |-> (left_idx <= size_ext && node_reg != '0))
        else $error("child compare issued outside the heap");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT && out_free && sts.size_one) |=> (count_reg == '0 && !ovf_reg))
        else $error("set state not cleared after the final result");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT && out_free) |=> (m_tvalid && m_tlast == $past(sts.size_one)))
        else $error("final-result flag does not match the heap size");

endmodule

// ===== rtl/core/hse_ctrl.sv =====
`timescale 1ns / 1ps

module hse_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  hse_pkg::sts_t  sts,
    output hse_pkg::op_t   op
);

    import hse_pkg::*;

    localparam logic [3:0] ST_LOAD       = 4'd0;
    localparam logic [3:0] ST_BUILD_INIT = 4'd1;
    localparam logic [3:0] ST_SD_RN      = 4'd2;
    localparam logic [3:0] ST_SD_CUR     = 4'd3;
    localparam logic [3:0] ST_SD_RL      = 4'd4;
    localparam logic [3:0] ST_SD_RR      = 4'd5;
    localparam logic [3:0] ST_SD_CMP     = 4'd6;
    localparam logic [3:0] ST_SD_W1      = 4'd7;
    localparam logic [3:0] ST_SD_W2      = 4'd8;
    localparam logic [3:0] ST_BUILD_NEXT = 4'd9;
    localparam logic [3:0] ST_EX_RT      = 4'd10;
    localparam logic [3:0] ST_EX_RL      = 4'd11;
    localparam logic [3:0] ST_EX_MV      = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       extract_reg, extract_next;
    logic [3:0] sift_done_state;

    // Where a finished sift-down returns to depends on the phase.
    assign sift_done_state = extract_reg ? ST_EX_RT : ST_BUILD_NEXT;

    always_comb
    begin
        state_next   = state_reg;
        extract_next = extract_reg;
        op           = OP_NONE;
        unique case (state_reg)
            ST_LOAD:
            begin
                op = OP_LOAD;
                if (sts.last_beat)
                begin
                    state_next = ST_BUILD_INIT;
                end
            end
            ST_BUILD_INIT:
            begin
                op = OP_BUILD_INIT;
                if (sts.half_zero)
                begin
                    extract_next = 1'b1;
                    state_next   = ST_EX_RT;
                end
                else
                begin
                    extract_next = 1'b0;
                    state_next   = ST_SD_RN;
                end
            end
            ST_SD_RN:
            begin
                op         = OP_RD_NODE;
                state_next = ST_SD_CUR;
            end
            ST_SD_CUR:
            begin
                op         = OP_LATCH_CUR;
                state_next = ST_SD_RL;
            end
            ST_SD_RL:
            begin
                op         = OP_RD_LEFT;
                state_next = sts.left_out ? sift_done_state : ST_SD_RR;
            end
            ST_SD_RR:
            begin
                op         = OP_CMP_LEFT;
                state_next = ST_SD_CMP;
            end
            ST_SD_CMP:
            begin
                op         = OP_CMP_RIGHT;
                state_next = ST_SD_W1;
            end
            ST_SD_W1:
            begin
                op         = OP_WR_NODE;
                state_next = sts.swap ? ST_SD_W2 : sift_done_state;
            end
            ST_SD_W2:
            begin
                op         = OP_WR_BEST;
                state_next = ST_SD_RL;
            end
            ST_BUILD_NEXT:
            begin
                op = OP_BUILD_NEXT;
                if (sts.bidx_one)
                begin
                    extract_next = 1'b1;
                    state_next   = ST_EX_RT;
                end
                else
                begin
                    state_next = ST_SD_RN;
                end
            end
            ST_EX_RT:
            begin
                op         = OP_RD_ROOT;
                state_next = ST_EX_RL;
            end
            ST_EX_RL:
            begin
                op         = OP_RD_LAST;
                state_next = ST_EX_MV;
            end
            ST_EX_MV:
            begin
                op = OP_EMIT;
                if (sts.out_free)
                begin
                    state_next = sts.size_one ? ST_LOAD : ST_SD_RL;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            extract_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            extract_reg <= extract_next;
        end
    end

endmodule

// ===== rtl/core/heap_sort_engine_core.sv =====
`timescale 1ns / 1ps

// Heapsort engine for sets of up to MAX_ITEMS (64) signed 32-bit values.
// Values stream in one beat per cycle on the slave side; the beat with tlast
// set ends the set. Beats beyond the capacity are dropped, and every result
// of that set then carries tuser high. After the last beat the engine builds
// a heap in its single-port-write, registered-read store and emits the set on
// the master side, ascending when sort_order is 0 (less-than heap) and
// descending when it is 1 (greater-than heap), with tlast on the final result.
// The store's single read port sets the steps of each sift-down level:
// read left child, read right child, compare, and two writes for the swap.
// Building the heap sifts down every internal node; each extraction reads
// the root and the last entry and moves the last entry to the root, which
// is then sifted down.
// No new set is taken while a set is being sorted; the slave side reopens
// once the final result has entered the output register. sort_order must
// only be written while the engine is idle.
module heap_sort_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: sort_order
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last_item
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // last_result
    output logic        m_tuser    // [0] overflow
);

    import hse_pkg::*;

    op_t  op;
    sts_t sts;

    // The controller sequences load, heap build and extraction; it issues one
    // datapath operation per cycle and sees only the status flags back.
    hse_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .op    (op)
    );

    // The datapath owns the heap store, the set bookkeeping, the sift-down
    // registers and the output register that decouples the result stream.
    hse_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .sts       (sts),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
